>>> rtl/core/dri_pkg.sv
// shared types, constants and arithmetic helpers of the delta robot inverse kinematics block
`timescale 1ns / 1ps
package dri_pkg;

  localparam int SQ_STEPS     = 32;
  localparam int CORDIC_STEPS = 31;
  localparam int DEG_STEPS    = 2;
  localparam int DEG_BITS     = 20;
  localparam int DEG_W        = DEG_STEPS * DEG_BITS;
  localparam int ARM_LAT      = 4 + SQ_STEPS + 1 + CORDIC_STEPS + 1;
  localparam int PIPE_LAT     = 4 + ARM_LAT + 1 + DEG_STEPS + 1;

  localparam logic signed [35:0] SQRT3_Q30   = 36'sd1859775393;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [14:0]        DEG_MUL     = 15'd18000;
  localparam logic [7:0]         DEG_BIAS    = 8'd157;
  localparam logic [9:0]         DEG_DIV     = 10'd314;
  // ceil(2^38 / 314), exact quotient for every dividend below 2^29
  localparam logic [29:0]        DEG_RECIP   = 30'd875407347;
  localparam int                 DEG_RSH     = 38;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

  typedef enum logic [2:0] {
    REG_UPPER  = 3'd0,
    REG_LOWER  = 3'd1,
    REG_OFS_A  = 3'd2,
    REG_OFS_B  = 3'd3,
    REG_OFS_C  = 3'd4,
    REG_LIM_LO = 3'd5,
    REG_LIM_HI = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } dri_in_t;

  typedef struct packed {
    logic signed [31:0] joint_angle_0;
    logic signed [31:0] joint_angle_1;
    logic signed [31:0] joint_angle_2;
    logic               status;
  } dri_out_t;

  // root cell state plus what rides along to the angle stage
  typedef struct packed {
    logic [63:0]        v;
    logic [63:0]        res;
    logic signed [30:0] f;
    logic signed [31:0] den;
    logic               bad;
  } sq_t;

  typedef struct packed {
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] z;
    logic               spec;
    logic               neg;
    logic               bad;
  } cd_t;

  typedef struct packed {
    logic               ok;
    logic signed [34:0] thf;
  } arm_res_t;

  typedef struct packed {
    logic [DEG_W-1:0] n;
    logic [DEG_W-1:0] q;
    logic [8:0]       rem;
    logic             neg;
    logic             ok;
  } deg_t;

  // exact product, magnitude shifted toward zero
  function automatic logic signed [63:0] qmul(input logic signed [35:0] a,
                                              input logic signed [35:0] b,
                                              input int sh);
    logic [35:0] ma;
    logic [35:0] mb;
    logic [71:0] p;
    logic [63:0] r;
    ma = a[35] ? -a : a;
    mb = b[35] ? -b : b;
    p  = ma * mb;
    r  = 64'(p >> sh);
    return (a[35] ^ b[35]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [6:0] bitlen(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage

>>> rtl/core/dri_if.sv
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
interface dri_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/delta_robot_inverse_kinematics_top.sv
// top level: geometry front end, three arm solvers, degree conversion, config registers
//
// Usage:
//   target carries one end-effector position (pos_x, pos_y, pos_z) per beat,
//   joint returns three joint angles and a status per beat, one result per
//   position, in order. Values are signed fixed point with FRAC_BITS fraction bits.
//   Geometry and angle limits sit in seven APB registers at byte address 4*i;
//   write them only while no position is in flight.
//   One position per cycle is taken for as long as results are drained. The
//   pipeline depth comes from the 32-cell square root chain and the two 31-cell
//   arctangent chains of each arm, plus the product stages in front and the 2-cell
//   reciprocal division into degrees.
//   When joint is stalled the whole pipeline freezes and target.ready drops;
//   nothing is lost or repeated.
//   Reset empties the pipeline, sets the limits to +-205887 and clears the
//   other registers.
//   status 1 means the position is unreachable; all angles then read -100 degrees.
`timescale 1ns / 1ps
module delta_robot_inverse_kinematics_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  dri_if.sink         target,
  dri_if.source       joint,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dri_pkg::*;

  localparam logic signed [31:0] FAIL_ANGLE = -(32'sd100 <<< FRAC_BITS);

  // configuration
  logic [30:0]        upper_len, lower_len;
  logic signed [31:0] ofs_a, ofs_b, ofs_c, lim_lo, lim_hi;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= '0;
      lower_len <= '0;
      ofs_a     <= '0;
      ofs_b     <= '0;
      ofs_c     <= '0;
      lim_lo    <= -32'sd205887;
      lim_hi    <= 32'sd205887;
    end else if (wr) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_UPPER:  upper_len <= pwdata[30:0];
        REG_LOWER:  lower_len <= pwdata[30:0];
        REG_OFS_A:  ofs_a     <= pwdata;
        REG_OFS_B:  ofs_b     <= pwdata;
        REG_OFS_C:  ofs_c     <= pwdata;
        REG_LIM_LO: lim_lo    <= pwdata;
        REG_LIM_HI: lim_hi    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_UPPER:  prdata = {1'b0, upper_len};
      REG_LOWER:  prdata = {1'b0, lower_len};
      REG_OFS_A:  prdata = ofs_a;
      REG_OFS_B:  prdata = ofs_b;
      REG_OFS_C:  prdata = ofs_c;
      REG_LIM_LO: prdata = lim_lo;
      REG_LIM_HI: prdata = lim_hi;
      default:    prdata = '0;
    endcase
  end

  // pipeline control: everything advances together
  logic                ce;
  logic [PIPE_LAT-1:0] vld;

  assign ce           = !joint.valid || joint.ready;
  assign target.ready = ce;
  assign joint.valid  = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (ce) vld <= {vld[PIPE_LAT-2:0], target.valid};
  end

  // front end
  logic signed [35:0] ls, lls, as, bs, cs;
  logic signed [31:0] x0, y0, z0;
  logic signed [63:0] pa1, s1_1, s2_1, pf1, xx1, yy1, zz1, ll1, lw1;
  logic signed [63:0] aa1, bb1, cc1, xb1, yc1, ya1;
  logic signed [31:0] y1;
  logic signed [63:0] e0_2, e1_2, e2_2, f_2, s_2, bc_2, xb2_2, yc2_2, ga_2;
  logic signed [63:0] e_3 [3];
  logic signed [63:0] g_3 [3];
  logic signed [63:0] f_3;

  assign ls  = 36'($signed({1'b0, upper_len}));
  assign lls = 36'($signed({1'b0, lower_len}));
  assign as  = 36'(ofs_a);
  assign bs  = 36'(ofs_b);
  assign cs  = 36'(ofs_c);

  always_ff @(posedge clk) begin
    if (ce) begin
      x0 <= target.data.pos_x;
      y0 <= target.data.pos_y;
      z0 <= target.data.pos_z;

      pa1  <= qmul(ls, 36'(y0) + as, FRAC_BITS);
      s1_1 <= qmul(SQRT3_Q30, 36'(x0) + bs, 30);
      s2_1 <= qmul(SQRT3_Q30, 36'(x0) - bs, 30);
      pf1  <= qmul(36'(z0), ls, FRAC_BITS);
      xx1  <= qmul(36'(x0), 36'(x0), FRAC_BITS);
      yy1  <= qmul(36'(y0), 36'(y0), FRAC_BITS);
      zz1  <= qmul(36'(z0), 36'(z0), FRAC_BITS);
      ll1  <= qmul(ls, ls, FRAC_BITS);
      lw1  <= qmul(lls, lls, FRAC_BITS);
      aa1  <= qmul(as, as, FRAC_BITS);
      bb1  <= qmul(bs, bs, FRAC_BITS);
      cc1  <= qmul(cs, cs, FRAC_BITS);
      xb1  <= qmul(36'(x0), bs, FRAC_BITS);
      yc1  <= qmul(36'(y0), cs, FRAC_BITS);
      ya1  <= qmul(36'(y0), as, FRAC_BITS);
      y1   <= y0;

      e0_2  <= pa1 <<< 1;
      e1_2  <= -qmul(ls, 36'(s1_1 + 64'(y1) + 64'(ofs_c)), FRAC_BITS);
      e2_2  <= qmul(ls, 36'(s2_1 - 64'(y1) - 64'(ofs_c)), FRAC_BITS);
      f_2   <= pf1 <<< 1;
      s_2   <= xx1 + yy1 + zz1 + ll1 - lw1;
      bc_2  <= bb1 + cc1;
      xb2_2 <= xb1 <<< 1;
      yc2_2 <= yc1 <<< 1;
      ga_2  <= aa1 + (ya1 <<< 1);

      e_3[0] <= e0_2;
      e_3[1] <= e1_2;
      e_3[2] <= e2_2;
      f_3    <= f_2;
      g_3[0] <= s_2 + ga_2;
      g_3[1] <= s_2 + bc_2 + xb2_2 + yc2_2;
      g_3[2] <= s_2 + bc_2 - xb2_2 + yc2_2;
    end
  end

  // arms and degree conversion
  arm_res_t arm [3];
  deg_t     dg [3][DEG_STEPS + 1];
  logic     ok_all;

  assign ok_all = arm[0].ok && arm[1].ok && arm[2].ok;

  for (genvar a = 0; a < 3; a++) begin : g_arm
    logic [34:0] t;

    dri_arm #(.FRAC_BITS(FRAC_BITS)) u_arm (
      .clk(clk), .ce(ce), .e(e_3[a]), .f(f_3), .g(g_3[a]),
      .lim_lo(lim_lo), .lim_hi(lim_hi), .res(arm[a])
    );

    assign t = arm[a].thf[34] ? 35'(-arm[a].thf) : 35'(arm[a].thf);

    always_ff @(posedge clk) begin
      if (ce) begin
        dg[a][0].n   <= DEG_W'(t[26:0]) * DEG_W'(DEG_MUL) + DEG_W'(DEG_BIAS);
        dg[a][0].q   <= '0;
        dg[a][0].rem <= '0;
        dg[a][0].neg <= arm[a].thf[34];
        dg[a][0].ok  <= ok_all;
      end
    end

    for (genvar s = 0; s < DEG_STEPS; s++) begin : g_deg
      dri_deg_cell #(.STEP(s)) u_deg (.clk(clk), .ce(ce), .d(dg[a][s]), .q(dg[a][s + 1]));
    end
  end

  function automatic logic signed [31:0] sat_deg(input deg_t d);
    if (!d.neg) return (d.q > DEG_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(d.q[31:0]);
    return (d.q > DEG_W'(32'h80000000)) ? 32'sh80000000 : $signed(32'd0 - d.q[31:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (ce) begin
      joint.data.joint_angle_0 <= dg[0][DEG_STEPS].ok ? sat_deg(dg[0][DEG_STEPS]) : FAIL_ANGLE;
      joint.data.joint_angle_1 <= dg[0][DEG_STEPS].ok ? sat_deg(dg[1][DEG_STEPS]) : FAIL_ANGLE;
      joint.data.joint_angle_2 <= dg[0][DEG_STEPS].ok ? sat_deg(dg[2][DEG_STEPS]) : FAIL_ANGLE;
      joint.data.status        <= !dg[0][DEG_STEPS].ok;
    end
  end

  // unreachable result carries the fixed fail angle on every arm
  a_fail_angles: assert property (@(posedge clk) disable iff (rst)
    joint.valid && joint.data.status |->
      joint.data.joint_angle_0 == FAIL_ANGLE && joint.data.joint_angle_1 == FAIL_ANGLE &&
      joint.data.joint_angle_2 == FAIL_ANGLE)
    else $error("unreachable result without fail angles");

  a_reset_empty: assert property (@(posedge clk) rst |=> !joint.valid)
    else $error("result beat right after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    joint.valid && !joint.ready |-> !target.ready)
    else $error("input taken while pipeline frozen");
endmodule

>>> rtl/core/dri_sqrt_cell.sv
// one digit step of the pipelined integer square root
`timescale 1ns / 1ps
module dri_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic         ce,
  input  dri_pkg::sq_t d,
  output dri_pkg::sq_t q
);
  import dri_pkg::*;

  localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

  sq_t nxt;
  logic [63:0] trial;

  always_comb begin
    nxt   = d;
    trial = d.res + BIT;
    if (d.v >= trial) begin
      nxt.v   = d.v - trial;
      nxt.res = (d.res >> 1) + BIT;
    end else begin
      nxt.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) q <= nxt;
  end
endmodule

>>> rtl/core/dri_cordic_cell.sv
// one vectoring rotation of the arctangent chain
`timescale 1ns / 1ps
module dri_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic         ce,
  input  dri_pkg::cd_t d,
  output dri_pkg::cd_t q
);
  import dri_pkg::*;

  localparam logic signed [33:0] TAB = $signed(34'(ATAN_TAB[STEP]));

  cd_t nxt;
  logic signed [33:0] cx, cy, dx, dy;

  always_comb begin
    nxt = d;
    cx  = d.cx;
    cy  = d.cy;
    dx  = cy >>> STEP;
    dy  = cx >>> STEP;
    // special angles ride through untouched
    if (!d.spec) begin
      if (cy > 0) begin
        nxt.cx = cx + dx;
        nxt.cy = cy - dy;
        nxt.z  = d.z + TAB;
      end else begin
        nxt.cx = cx - dx;
        nxt.cy = cy + dy;
        nxt.z  = d.z - TAB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) q <= nxt;
  end
endmodule

>>> rtl/core/dri_deg_cell.sv
// one twenty-bit quotient digit of the radians to degrees division
`timescale 1ns / 1ps
module dri_deg_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          ce,
  input  dri_pkg::deg_t d,
  output dri_pkg::deg_t q
);
  import dri_pkg::*;

  localparam int HI = DEG_W - 1 - DEG_BITS * STEP;
  localparam int XW = DEG_BITS + 9;

  deg_t nxt;
  logic [XW-1:0]       x;
  logic [XW+29:0]      prod;
  logic [DEG_BITS-1:0] qd;

  // partial remainder joined with the next digit stays below 314 * 2^20
  always_comb begin
    nxt  = d;
    x    = {d.rem, d.n[HI -: DEG_BITS]};
    prod = (XW + 30)'(x) * (XW + 30)'(DEG_RECIP);
    qd   = DEG_BITS'(prod >> DEG_RSH);
    nxt.q[HI -: DEG_BITS] = qd;
    nxt.rem = 9'(x - XW'(qd) * XW'(DEG_DIV));
  end

  always_ff @(posedge clk) begin
    if (ce) q <= nxt;
  end
endmodule

>>> rtl/core/dri_arm.sv
// per-arm solver: scaling, discriminant, root chain, two arctangent chains, limit pick
`timescale 1ns / 1ps
module dri_arm #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    ce,
  input  logic signed [63:0]      e,
  input  logic signed [63:0]      f,
  input  logic signed [63:0]      g,
  input  logic signed [31:0]      lim_lo,
  input  logic signed [31:0]      lim_hi,
  output dri_pkg::arm_res_t       res
);
  import dri_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [34:0] RND = 35'(1) <<< (SH - 1);

  logic signed [63:0] e1, f1, g1;
  logic [5:0]         k1;
  logic signed [30:0] e2, f2, g2;
  logic signed [61:0] ee3, ff3, gg3;
  logic signed [30:0] f3;
  logic signed [31:0] den3;
  logic signed [62:0] disc;
  logic [6:0]         bl;

  sq_t sq [SQ_STEPS + 1];
  cd_t cd0 [CORDIC_STEPS + 1];
  cd_t cd1 [CORDIC_STEPS + 1];

  logic signed [33:0] f34, r34;
  logic signed [34:0] th0, th1;
  logic ok0, ok1;

  function automatic logic signed [30:0] shrink(input logic signed [63:0] v,
                                                input logic [5:0] k);
    logic [63:0] m;
    m = mag64(v) >> k;
    return v[63] ? 31'(64'(0) - m) : 31'(m);
  endfunction

  function automatic cd_t cd_init(input logic signed [33:0] num,
                                  input logic signed [31:0] den,
                                  input logic bad);
    cd_t c;
    logic [33:0] x, y, m;
    logic [6:0]  b;
    c = '0;
    c.bad = bad;
    x = den[31] ? 34'(-den) : 34'(den);
    y = num[33] ? 34'(-num) : 34'(num);
    m = (x > y) ? x : y;
    b = bitlen(64'(m));
    if (den == 0) begin
      c.spec = 1'b1;
      c.z    = num[33] ? -HALF_PI_Q30 : HALF_PI_Q30;
    end else if (num == 0) begin
      c.spec = 1'b1;
    end else begin
      // bring the larger operand into [2^29, 2^30)
      if (b > 7'd30) begin
        x = x >> (b - 7'd30);
        y = y >> (b - 7'd30);
      end else begin
        x = x << (7'd30 - b);
        y = y << (7'd30 - b);
      end
      c.cx  = $signed(x);
      c.cy  = $signed(y);
      c.neg = num[33] ^ den[31];
    end
    return c;
  endfunction

  function automatic logic signed [34:0] to_q(input cd_t c);
    logic signed [33:0] a;
    logic signed [34:0] th;
    a  = c.neg ? -c.z : c.z;
    th = 35'(a) <<< 1;
    return (th + RND) >>> SH;
  endfunction

  assign bl = bitlen(mag64(e) | mag64(f) | mag64(g));

  always_ff @(posedge clk) begin
    if (ce) begin
      e1 <= e;
      f1 <= f;
      g1 <= g;
      k1 <= (bl > 7'd30) ? 6'(bl - 7'd30) : 6'd0;
      e2 <= shrink(e1, k1);
      f2 <= shrink(f1, k1);
      g2 <= shrink(g1, k1);
      ee3  <= e2 * e2;
      ff3  <= f2 * f2;
      gg3  <= g2 * g2;
      f3   <= f2;
      den3 <= 32'(g2) - 32'(e2);
    end
  end

  assign disc = 63'(ff3) + 63'(ee3) - 63'(gg3);

  always_ff @(posedge clk) begin
    if (ce) begin
      sq[0].v   <= disc[62] ? 64'd0 : 64'(disc);
      sq[0].res <= '0;
      sq[0].f   <= f3;
      sq[0].den <= den3;
      sq[0].bad <= disc[62];
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    dri_sqrt_cell #(.STEP(i)) u_cell (.clk(clk), .ce(ce), .d(sq[i]), .q(sq[i + 1]));
  end

  assign f34 = 34'(sq[SQ_STEPS].f);
  assign r34 = $signed({2'b00, sq[SQ_STEPS].res[31:0]});

  always_ff @(posedge clk) begin
    if (ce) begin
      cd0[0] <= cd_init(-f34 + r34, sq[SQ_STEPS].den, sq[SQ_STEPS].bad);
      cd1[0] <= cd_init(-f34 - r34, sq[SQ_STEPS].den, sq[SQ_STEPS].bad);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cd
    dri_cordic_cell #(.STEP(i)) u_plus  (.clk(clk), .ce(ce), .d(cd0[i]), .q(cd0[i + 1]));
    dri_cordic_cell #(.STEP(i)) u_minus (.clk(clk), .ce(ce), .d(cd1[i]), .q(cd1[i + 1]));
  end

  assign th0 = to_q(cd0[CORDIC_STEPS]);
  assign th1 = to_q(cd1[CORDIC_STEPS]);
  assign ok0 = (th0 >= 35'(lim_lo)) && (th0 <= 35'(lim_hi));
  assign ok1 = (th1 >= 35'(lim_lo)) && (th1 <= 35'(lim_hi));

  // plus root wins when both fit
  always_ff @(posedge clk) begin
    if (ce) begin
      res.ok  <= !cd0[CORDIC_STEPS].bad && (ok0 || ok1);
      res.thf <= ok0 ? th0 : th1;
    end
  end
endmodule
